@@ design/lrukv_pkg.sv @@
// Shared constants, codes and types for the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

  // Default geometry handed to the top-level parameters.
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Capacity register.
  localparam int              CAP_W          = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Register word indexes on the APB port.
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_index_t;

  // Request kinds carried in the slave-side tuser.
  typedef enum logic [0:0] {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_type_t;

  // Per-request control broadcast to every cell of the row.
  typedef struct packed {
    logic accept;      // a request is taken this cycle
    logic insert_new;  // put on an absent key: the whole row shifts down
    logic evict;       // the least recent entry falls off the end
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/lrukv_cell.sv @@
// One entry of the recency-ordered cell row: key, value and valid flag.
`default_nettype none

module lrukv_cell #(
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrukv_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic                  prev_valid,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic                  hit_below_in,
  output logic                  hit_below_out,
  output logic                  match,
  output logic                  valid,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value
);

  logic take_prev;
  logic valid_next;

  assign match         = valid && (key == lookup_key);
  // True when the hit entry sits in this cell or further down the row.
  assign hit_below_out = match | hit_below_in;

  // A cell moves its neighbor's entry in when a new key is inserted, or when
  // the touched entry lies at or behind it.
  assign take_prev  = ctrl.accept && (ctrl.insert_new || hit_below_out);
  // On eviction the first empty cell must stay empty, so the entry shifted
  // into it from the last valid cell is dropped.
  assign valid_next = prev_valid && (!ctrl.evict || valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_prev) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_prev) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule

`default_nettype wire

@@ design/lrukv_apb.sv @@
// APB register block holding the capacity register.
`default_nettype none

module lrukv_apb (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [lrukv_pkg::CAP_W-1:0] capacity
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[2] == lrukv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAPACITY_RESET;
    end else if (wr_en) begin
      capacity <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      lrukv_pkg::REG_CAPACITY: prdata = 32'(capacity);
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
//  Channel    | Signals                          | Direction | Content
//  -----------+----------------------------------+-----------+---------------------------
//  request    | s_axis_tvalid/tready/tdata/tuser | in        | tuser: req_type; tdata: key, value
//  result     | m_axis_tvalid/tready/tdata/tuser | out       | tuser: found; tdata: read_value
//  config     | psel/penable/pwrite/paddr/...    | in/out    | capacity register at address 0
//
// One request is taken per clock cycle while the result stream is not stalled. All cells
// compare the key in the same cycle and the row of cells reorders itself in that cycle, so
// the compare across the row plus the shift into each cell sets the cycle time.
// The result of a request appears in the output register on the next cycle.
// Reset clears every valid flag and the entry count at once; no clearing
// sweep runs, and the first request may follow reset directly.
// A stalled result holds the output register, and a new request is taken
// only when that register is empty or is being drained in the same cycle.
//
// The cells are kept in recency order: cell 0 holds the most recent entry and
// the valid entries always occupy a contiguous run from cell 0. A touched
// entry moves to cell 0 while the cells in front of it shift back by one; a
// new key enters at cell 0 and pushes the whole row back, and when the cache
// is full the last valid entry falls out.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  // Request stream.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0 up: key, value, zero fill to whole bytes.
  input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // Fields from bit 0 up: req_type.
  input  logic s_axis_tuser,

  // Result stream.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0 up: read_value, zero fill to whole bytes.
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Fields from bit 0 up: found.
  output logic m_axis_tuser,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int CMP_W       = ((CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W) + 1;

  logic [lrukv_pkg::CAP_W-1:0] capacity;

  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic                  is_put;
  logic                  accept;

  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES:0]      hit_chain;
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];

  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS-1:0] head_value;

  logic [CNT_W-1:0] used_count;
  logic [CMP_W-1:0] used_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic             full;

  lrukv_pkg::cell_ctrl_t ctrl;

  logic                  out_found;
  logic [VALUE_BITS-1:0] read_value;

  // Configuration register.
  lrukv_apb u_apb (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Request unpacking and handshake.
  assign in_key        = s_axis_tdata[KEY_BITS-1:0];
  assign in_value      = s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
  assign is_put        = (s_axis_tuser == lrukv_pkg::REQ_PUT);
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Effective capacity: zero acts as one, anything above the row length as the
  // row length.
  assign used_ext = CMP_W'(used_count);
  assign cap_ext  = CMP_W'(capacity);
  always_comb begin
    priority if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = (used_ext >= cap_eff);

  // Hit search: the chain runs from the last cell toward cell 0, so its head
  // says whether any cell matched.
  assign hit_chain[ENTRIES] = 1'b0;
  assign any_hit            = hit_chain[0];

  // Keys are unique among valid cells, so at most one term is nonzero.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match_vec[i] ? cell_value[i] : '0);
    end
  end

  // What enters cell 0: a put carries its new value, a get hit keeps the old.
  assign head_value = is_put ? in_value : hit_value;

  assign ctrl.accept     = accept;
  assign ctrl.insert_new = is_put && !any_hit;
  assign ctrl.evict      = is_put && !any_hit && full;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                  prev_valid;
    logic [KEY_BITS-1:0]   prev_key;
    logic [VALUE_BITS-1:0] prev_value;

    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_key   = in_key;
      assign prev_value = head_value;
    end else begin : g_body
      assign prev_valid = valid_vec[g-1];
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
    end

    lrukv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .lookup_key    (in_key),
      .prev_valid    (prev_valid),
      .prev_key      (prev_key),
      .prev_value    (prev_value),
      .hit_below_in  (hit_chain[g+1]),
      .hit_below_out (hit_chain[g]),
      .match         (match_vec[g]),
      .valid         (valid_vec[g]),
      .key           (cell_key[g]),
      .value         (cell_value[g])
    );
  end

  // Entry count: grows only on an insert that evicts nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (accept && ctrl.insert_new && !ctrl.evict) begin
      used_count <= used_count + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found  <= any_hit;
      read_value <= (!is_put && any_hit) ? hit_value : '0;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(read_value);
  assign m_axis_tuser = out_found;

`ifndef SYNTH
  // The valid cells always form one run starting at cell 0.
  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}))
    else $error("valid cells are not contiguous from cell 0");

  // The entry count tracks the number of valid cells.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(used_count))
    else $error("entry count disagrees with valid cells");

  // A key is held by at most one cell.
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("key matched in more than one cell");

  // An insert that evicts leaves the count unchanged.
  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.evict) |=> $stable(used_count))
    else $error("entry count changed on an evicting insert");

  // A taken request always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
